@@ design/dgcc_pkg.sv @@
// ----------------------------------------------------------------------------
// dgcc_pkg
// Shared sizes, codes and controller/datapath interface types for the
// dependency graph cycle checker.
// ----------------------------------------------------------------------------
package dgcc_pkg;

   localparam int MAX_NODES   = 256;
   localparam int MAX_EDGES   = 1024;
   localparam int STACK_DEPTH = 128;
   localparam int ID_BITS     = 32;

   localparam int NODE_AW  = $clog2(MAX_NODES);
   localparam int NCNT_W   = $clog2(MAX_NODES + 1);
   localparam int EDGE_AW  = $clog2(MAX_EDGES);
   localparam int ECNT_W   = $clog2(MAX_EDGES + 1);
   localparam int STK_AW   = $clog2(STACK_DEPTH);
   localparam int SP_W     = $clog2(STACK_DEPTH + 1);
   localparam int BOUNDS_W = 2 * ECNT_W;
   localparam int MARK_W   = 2;
   localparam int STATUS_W = 3;

   // Walk marks of one node.
   localparam logic [MARK_W-1:0] MARK_NEW  = 2'd0;
   localparam logic [MARK_W-1:0] MARK_OPEN = 2'd1;
   localparam logic [MARK_W-1:0] MARK_DONE = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK             = 3'd0,
      ST_ZERO_NODE      = 3'd1,
      ST_ZERO_PREREQ    = 3'd2,
      ST_SELF_PREREQ    = 3'd3,
      ST_MISSING_PREREQ = 3'd4,
      ST_CYCLE          = 3'd5,
      ST_TOO_DEEP       = 3'd6,
      ST_OVERFLOW       = 3'd7
   } status_code_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_INIT,
      OP_V_RD_NODE,
      OP_V_GOT_NODE,
      OP_V_EDGE_RD,
      OP_V_TGT,
      OP_S_RD,
      OP_S_NEXT,
      OP_V_FOUND,
      OP_R_START,
      OP_R_FOUND,
      OP_CLR_INIT,
      OP_CLR,
      OP_D_INIT,
      OP_D_SI_RD,
      OP_D_SI_NEXT,
      OP_D_PUSH_SI,
      OP_D_TOP_RD,
      OP_D_IDX,
      OP_D_POP,
      OP_D_ENTER,
      OP_D_REC,
      OP_D_BND,
      OP_D_E_RD,
      OP_D_E_GOT,
      OP_D_E_NEXT,
      OP_D_PUSH,
      OP_D_FINISH,
      OP_FAIL,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type          op;
      status_code_type code;
   } cmd_type;

   typedef struct packed {
      logic ovf;
      logic n_done;
      logic id_zero;
      logic e_done;
      logic key_zero;
      logic key_self;
      logic k_done;
      logic k_match;
      logic si_done;
      logic mark_new;
      logic mark_open;
      logic sp_zero;
      logic stack_full;
      logic rsp_busy;
   } sts_type;

endpackage

@@ design/dgcc_ram.sv @@
// ----------------------------------------------------------------------------
// dgcc_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module dgcc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/dgcc_ctrl.sv @@
// ----------------------------------------------------------------------------
// dgcc_ctrl
// Sequencer for loading, validation, walk-mark clearing, depth-first cycle
// search and result hand-off.
// ----------------------------------------------------------------------------
module dgcc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_last_of_graph,
   output logic             req_ready,
   input  dgcc_pkg::sts_type sts,
   output dgcc_pkg::cmd_type cmd
);

   typedef enum logic [4:0] {
      S_LOAD, S_CHK, S_V_NODE, S_V_GOT, S_V_EDGE, S_V_TGT, S_V_CHK,
      S_E_RD, S_E_CMP, S_R_RD, S_R_CMP, S_CLR, S_D_SI, S_D_SI_CHK,
      S_D_TOP, S_D_IDX, S_D_MARK, S_D_REC, S_D_BND, S_D_EDGE, S_D_EGOT,
      S_D_EMARK, S_DONE
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd.op   = dgcc_pkg::OP_NONE;
      cmd.code = dgcc_pkg::ST_OK;
      unique case (state_ff)
         S_LOAD: begin
            if (req_valid) begin
               cmd.op = dgcc_pkg::OP_LOAD;
               if (req_last_of_graph) begin
                  state_in = S_CHK;
               end
            end
         end
         S_CHK: begin
            if (sts.ovf) begin
               cmd.op   = dgcc_pkg::OP_FAIL;
               cmd.code = dgcc_pkg::ST_OVERFLOW;
               state_in = S_DONE;
            end else begin
               cmd.op   = dgcc_pkg::OP_INIT;
               state_in = S_V_NODE;
            end
         end
         S_V_NODE: begin
            if (sts.n_done) begin
               cmd.op   = dgcc_pkg::OP_CLR_INIT;
               state_in = S_CLR;
            end else begin
               cmd.op   = dgcc_pkg::OP_V_RD_NODE;
               state_in = S_V_GOT;
            end
         end
         S_V_GOT: begin
            if (sts.id_zero) begin
               cmd.op   = dgcc_pkg::OP_FAIL;
               cmd.code = dgcc_pkg::ST_ZERO_NODE;
               state_in = S_DONE;
            end else begin
               cmd.op   = dgcc_pkg::OP_V_GOT_NODE;
               state_in = S_V_EDGE;
            end
         end
         S_V_EDGE: begin
            if (sts.e_done) begin
               cmd.op   = dgcc_pkg::OP_R_START;
               state_in = S_R_RD;
            end else begin
               cmd.op   = dgcc_pkg::OP_V_EDGE_RD;
               state_in = S_V_TGT;
            end
         end
         S_V_TGT: begin
            cmd.op   = dgcc_pkg::OP_V_TGT;
            state_in = S_V_CHK;
         end
         S_V_CHK: begin
            if (sts.key_zero) begin
               cmd.op   = dgcc_pkg::OP_FAIL;
               cmd.code = dgcc_pkg::ST_ZERO_PREREQ;
               state_in = S_DONE;
            end else if (sts.key_self) begin
               cmd.op   = dgcc_pkg::OP_FAIL;
               cmd.code = dgcc_pkg::ST_SELF_PREREQ;
               state_in = S_DONE;
            end else begin
               state_in = S_E_RD;
            end
         end
         S_E_RD: begin
            if (sts.k_done) begin
               cmd.op   = dgcc_pkg::OP_FAIL;
               cmd.code = dgcc_pkg::ST_MISSING_PREREQ;
               state_in = S_DONE;
            end else begin
               cmd.op   = dgcc_pkg::OP_S_RD;
               state_in = S_E_CMP;
            end
         end
         S_E_CMP: begin
            if (sts.k_match) begin
               cmd.op   = dgcc_pkg::OP_V_FOUND;
               state_in = S_V_EDGE;
            end else begin
               cmd.op   = dgcc_pkg::OP_S_NEXT;
               state_in = S_E_RD;
            end
         end
         S_R_RD: begin
            cmd.op   = dgcc_pkg::OP_S_RD;
            state_in = S_R_CMP;
         end
         S_R_CMP: begin
            if (sts.k_match) begin
               cmd.op   = dgcc_pkg::OP_R_FOUND;
               state_in = S_V_NODE;
            end else begin
               cmd.op   = dgcc_pkg::OP_S_NEXT;
               state_in = S_R_RD;
            end
         end
         S_CLR: begin
            if (sts.k_done) begin
               cmd.op   = dgcc_pkg::OP_D_INIT;
               state_in = S_D_SI;
            end else begin
               cmd.op = dgcc_pkg::OP_CLR;
            end
         end
         S_D_SI: begin
            if (sts.si_done) begin
               cmd.op   = dgcc_pkg::OP_FAIL;
               cmd.code = dgcc_pkg::ST_OK;
               state_in = S_DONE;
            end else begin
               cmd.op   = dgcc_pkg::OP_D_SI_RD;
               state_in = S_D_SI_CHK;
            end
         end
         S_D_SI_CHK: begin
            if (sts.mark_new) begin
               cmd.op   = dgcc_pkg::OP_D_PUSH_SI;
               state_in = S_D_TOP;
            end else begin
               cmd.op   = dgcc_pkg::OP_D_SI_NEXT;
               state_in = S_D_SI;
            end
         end
         S_D_TOP: begin
            if (sts.sp_zero) begin
               cmd.op   = dgcc_pkg::OP_D_SI_NEXT;
               state_in = S_D_SI;
            end else begin
               cmd.op   = dgcc_pkg::OP_D_TOP_RD;
               state_in = S_D_IDX;
            end
         end
         S_D_IDX: begin
            cmd.op   = dgcc_pkg::OP_D_IDX;
            state_in = S_D_MARK;
         end
         S_D_MARK: begin
            if (!sts.mark_new && !sts.mark_open) begin
               cmd.op   = dgcc_pkg::OP_D_POP;
               state_in = S_D_TOP;
            end else begin
               cmd.op   = dgcc_pkg::OP_D_ENTER;
               state_in = S_D_REC;
            end
         end
         S_D_REC: begin
            cmd.op   = dgcc_pkg::OP_D_REC;
            state_in = S_D_BND;
         end
         S_D_BND: begin
            cmd.op   = dgcc_pkg::OP_D_BND;
            state_in = S_D_EDGE;
         end
         S_D_EDGE: begin
            if (sts.e_done) begin
               cmd.op   = dgcc_pkg::OP_D_FINISH;
               state_in = S_D_TOP;
            end else begin
               cmd.op   = dgcc_pkg::OP_D_E_RD;
               state_in = S_D_EGOT;
            end
         end
         S_D_EGOT: begin
            cmd.op   = dgcc_pkg::OP_D_E_GOT;
            state_in = S_D_EMARK;
         end
         S_D_EMARK: begin
            if (sts.mark_open) begin
               cmd.op   = dgcc_pkg::OP_FAIL;
               cmd.code = dgcc_pkg::ST_CYCLE;
               state_in = S_DONE;
            end else if (sts.mark_new && sts.stack_full) begin
               cmd.op   = dgcc_pkg::OP_FAIL;
               cmd.code = dgcc_pkg::ST_TOO_DEEP;
               state_in = S_DONE;
            end else if (sts.mark_new) begin
               cmd.op   = dgcc_pkg::OP_D_PUSH;
               state_in = S_D_TOP;
            end else begin
               cmd.op   = dgcc_pkg::OP_D_E_NEXT;
               state_in = S_D_EDGE;
            end
         end
         S_DONE: begin
            if (!sts.rsp_busy) begin
               cmd.op   = dgcc_pkg::OP_EMIT;
               state_in = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_LOAD);

endmodule

@@ design/dgcc_datapath.sv @@
// ----------------------------------------------------------------------------
// dgcc_datapath
// Graph tables, load counters, walk registers and the result register.
// ----------------------------------------------------------------------------
module dgcc_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [dgcc_pkg::ID_BITS-1:0]     req_node_id,
   input  logic [dgcc_pkg::ID_BITS-1:0]     req_prereq_id,
   input  logic                             req_has_prereq,
   input  logic                             req_last_of_node,
   input  logic                             req_last_of_graph,
   input  dgcc_pkg::cmd_type                cmd,
   output dgcc_pkg::sts_type                sts,
   input  logic                             rsp_ready,
   output logic                             rsp_valid,
   output logic [dgcc_pkg::STATUS_W-1:0]    rsp_status,
   output logic [dgcc_pkg::ID_BITS-1:0]     rsp_bad_node_id,
   output logic [dgcc_pkg::ID_BITS-1:0]     rsp_bad_prereq_id
);

   localparam int NODE_AW  = dgcc_pkg::NODE_AW;
   localparam int NCNT_W   = dgcc_pkg::NCNT_W;
   localparam int EDGE_AW  = dgcc_pkg::EDGE_AW;
   localparam int ECNT_W   = dgcc_pkg::ECNT_W;
   localparam int STK_AW   = dgcc_pkg::STK_AW;
   localparam int SP_W     = dgcc_pkg::SP_W;
   localparam int ID_W     = dgcc_pkg::ID_BITS;
   localparam int BOUNDS_W = dgcc_pkg::BOUNDS_W;
   localparam int MARK_W   = dgcc_pkg::MARK_W;

   // Load state.
   logic [NCNT_W-1:0] nc_ff;
   logic [ECNT_W-1:0] ec_ff;
   logic              ovf_ff;
   logic              open_ff;
   logic [ECNT_W-1:0] cur_start_ff;

   // Check and walk registers.
   logic [NCNT_W-1:0]  n_ff, k_ff, si_ff;
   logic [ECNT_W-1:0]  e_ff, end_ff;
   logic [ID_W-1:0]    id_ff, key_ff, recid_ff, tgt_ff;
   logic [NODE_AW-1:0] idx_ff, pj_ff;
   logic [SP_W-1:0]    sp_ff;

   // Result register.
   dgcc_pkg::status_code_type       res_code_ff;
   logic [ID_W-1:0]                 res_node_ff, res_pre_ff;
   logic                            rsp_valid_ff;
   logic [dgcc_pkg::STATUS_W-1:0]   rsp_status_ff;
   logic [ID_W-1:0]                 rsp_node_ff, rsp_pre_ff;

   // Memory ports.
   logic [NODE_AW-1:0]  node_rd_addr;
   logic [ID_W-1:0]     node_rd;
   logic [BOUNDS_W-1:0] bnd_rd, bnd_wr_data;
   logic [NODE_AW-1:0]  bnd_wr_addr;
   logic [ID_W-1:0]     tgt_rd;
   logic [NODE_AW-1:0]  tidx_rd, rec_rd, stack_rd;
   logic                mark_wr_en;
   logic [NODE_AW-1:0]  mark_wr_addr, mark_rd_addr;
   logic [MARK_W-1:0]   mark_wr_data, mark_rd;
   logic                stack_wr_en;
   logic [STK_AW-1:0]   stack_wr_addr;
   logic [NODE_AW-1:0]  stack_wr_data;
   logic [SP_W-1:0]     sp_dec;

   // Load decisions for an accepted item.
   logic              is_load, create, node_ovf, open_after, edge_try, add_edge, edge_ovf;
   logic [ECNT_W-1:0] ec_next, start_sel;
   logic [NCNT_W-1:0] nc_dec;

   assign is_load    = (cmd.op == dgcc_pkg::OP_LOAD);
   assign create     = is_load && !ovf_ff && !open_ff
                       && (nc_ff < NCNT_W'(dgcc_pkg::MAX_NODES));
   assign node_ovf   = is_load && !ovf_ff && !open_ff && !create;
   assign open_after = open_ff || create;
   assign edge_try   = is_load && !ovf_ff && !node_ovf && open_after && req_has_prereq;
   assign add_edge   = edge_try && (ec_ff < ECNT_W'(dgcc_pkg::MAX_EDGES));
   assign edge_ovf   = edge_try && !add_edge;
   assign ec_next    = ec_ff + ECNT_W'(add_edge);
   assign start_sel  = create ? ec_ff : cur_start_ff;
   assign nc_dec     = nc_ff - NCNT_W'(1);
   assign bnd_wr_addr = create ? nc_ff[NODE_AW-1:0] : nc_dec[NODE_AW-1:0];
   assign bnd_wr_data = {start_sel, ec_next};
   assign sp_dec      = sp_ff - SP_W'(1);

   always_comb begin
      node_rd_addr = k_ff[NODE_AW-1:0];
      mark_rd_addr = si_ff[NODE_AW-1:0];
      mark_wr_en   = 1'b0;
      mark_wr_addr = idx_ff;
      mark_wr_data = dgcc_pkg::MARK_NEW;
      stack_wr_en   = 1'b0;
      stack_wr_addr = sp_ff[STK_AW-1:0];
      stack_wr_data = pj_ff;
      unique case (cmd.op)
         dgcc_pkg::OP_V_RD_NODE: node_rd_addr = n_ff[NODE_AW-1:0];
         dgcc_pkg::OP_D_REC:     node_rd_addr = rec_rd;
         dgcc_pkg::OP_D_IDX:     mark_rd_addr = stack_rd;
         dgcc_pkg::OP_D_E_GOT:   mark_rd_addr = tidx_rd;
         dgcc_pkg::OP_CLR: begin
            mark_wr_en   = 1'b1;
            mark_wr_addr = k_ff[NODE_AW-1:0];
         end
         dgcc_pkg::OP_D_ENTER: begin
            mark_wr_en   = 1'b1;
            mark_wr_data = dgcc_pkg::MARK_OPEN;
         end
         dgcc_pkg::OP_D_FINISH: begin
            mark_wr_en   = 1'b1;
            mark_wr_data = dgcc_pkg::MARK_DONE;
         end
         dgcc_pkg::OP_D_PUSH_SI: begin
            stack_wr_en   = 1'b1;
            stack_wr_addr = '0;
            stack_wr_data = si_ff[NODE_AW-1:0];
         end
         dgcc_pkg::OP_D_PUSH: stack_wr_en = 1'b1;
         default: ;
      endcase
   end

   dgcc_ram #(.WIDTH(ID_W), .DEPTH(dgcc_pkg::MAX_NODES)) u_node_ram (
      .clock(clock), .wr_en(create), .wr_addr(nc_ff[NODE_AW-1:0]),
      .wr_data(req_node_id), .rd_addr(node_rd_addr), .rd_data(node_rd));

   dgcc_ram #(.WIDTH(BOUNDS_W), .DEPTH(dgcc_pkg::MAX_NODES)) u_bounds_ram (
      .clock(clock), .wr_en(create || add_edge), .wr_addr(bnd_wr_addr),
      .wr_data(bnd_wr_data), .rd_addr(node_rd_addr), .rd_data(bnd_rd));

   dgcc_ram #(.WIDTH(ID_W), .DEPTH(dgcc_pkg::MAX_EDGES)) u_target_ram (
      .clock(clock), .wr_en(add_edge), .wr_addr(ec_ff[EDGE_AW-1:0]),
      .wr_data(req_prereq_id), .rd_addr(e_ff[EDGE_AW-1:0]), .rd_data(tgt_rd));

   dgcc_ram #(.WIDTH(NODE_AW), .DEPTH(dgcc_pkg::MAX_EDGES)) u_tindex_ram (
      .clock(clock), .wr_en(cmd.op == dgcc_pkg::OP_V_FOUND),
      .wr_addr(e_ff[EDGE_AW-1:0]), .wr_data(k_ff[NODE_AW-1:0]),
      .rd_addr(e_ff[EDGE_AW-1:0]), .rd_data(tidx_rd));

   dgcc_ram #(.WIDTH(NODE_AW), .DEPTH(dgcc_pkg::MAX_NODES)) u_record_ram (
      .clock(clock), .wr_en(cmd.op == dgcc_pkg::OP_R_FOUND),
      .wr_addr(n_ff[NODE_AW-1:0]), .wr_data(k_ff[NODE_AW-1:0]),
      .rd_addr(idx_ff), .rd_data(rec_rd));

   dgcc_ram #(.WIDTH(MARK_W), .DEPTH(dgcc_pkg::MAX_NODES)) u_mark_ram (
      .clock(clock), .wr_en(mark_wr_en), .wr_addr(mark_wr_addr),
      .wr_data(mark_wr_data), .rd_addr(mark_rd_addr), .rd_data(mark_rd));

   dgcc_ram #(.WIDTH(NODE_AW), .DEPTH(dgcc_pkg::STACK_DEPTH)) u_stack_ram (
      .clock(clock), .wr_en(stack_wr_en), .wr_addr(stack_wr_addr),
      .wr_data(stack_wr_data), .rd_addr(sp_dec[STK_AW-1:0]), .rd_data(stack_rd));

   always_ff @(posedge clock) begin
      if (reset) begin
         nc_ff        <= '0;
         ec_ff        <= '0;
         ovf_ff       <= 1'b0;
         open_ff      <= 1'b0;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && (cmd.op != dgcc_pkg::OP_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (cmd.op)
            dgcc_pkg::OP_LOAD: begin
               nc_ff        <= nc_ff + NCNT_W'(create);
               ec_ff        <= ec_next;
               ovf_ff       <= ovf_ff || node_ovf || edge_ovf;
               open_ff      <= (req_last_of_node || req_last_of_graph) ? 1'b0 : open_after;
               cur_start_ff <= start_sel;
            end
            dgcc_pkg::OP_INIT:      n_ff <= '0;
            dgcc_pkg::OP_V_GOT_NODE: begin
               id_ff  <= node_rd;
               e_ff   <= bnd_rd[BOUNDS_W-1:ECNT_W];
               end_ff <= bnd_rd[ECNT_W-1:0];
            end
            dgcc_pkg::OP_V_TGT: begin
               key_ff <= tgt_rd;
               k_ff   <= '0;
            end
            dgcc_pkg::OP_R_START: begin
               key_ff <= id_ff;
               k_ff   <= '0;
            end
            dgcc_pkg::OP_S_NEXT, dgcc_pkg::OP_CLR: k_ff <= k_ff + NCNT_W'(1);
            dgcc_pkg::OP_V_FOUND, dgcc_pkg::OP_D_E_NEXT: e_ff <= e_ff + ECNT_W'(1);
            dgcc_pkg::OP_R_FOUND:   n_ff <= n_ff + NCNT_W'(1);
            dgcc_pkg::OP_CLR_INIT:  k_ff <= '0;
            dgcc_pkg::OP_D_INIT:    si_ff <= '0;
            dgcc_pkg::OP_D_SI_NEXT: si_ff <= si_ff + NCNT_W'(1);
            dgcc_pkg::OP_D_PUSH_SI: sp_ff <= SP_W'(1);
            dgcc_pkg::OP_D_IDX:     idx_ff <= stack_rd;
            dgcc_pkg::OP_D_POP, dgcc_pkg::OP_D_FINISH: sp_ff <= sp_dec;
            dgcc_pkg::OP_D_BND: begin
               recid_ff <= node_rd;
               e_ff     <= bnd_rd[BOUNDS_W-1:ECNT_W];
               end_ff   <= bnd_rd[ECNT_W-1:0];
            end
            dgcc_pkg::OP_D_E_GOT: begin
               pj_ff  <= tidx_rd;
               tgt_ff <= tgt_rd;
            end
            dgcc_pkg::OP_D_PUSH:    sp_ff <= sp_ff + SP_W'(1);
            dgcc_pkg::OP_FAIL: begin
               res_code_ff <= cmd.code;
               case (cmd.code) inside
                  dgcc_pkg::ST_ZERO_PREREQ: begin
                     res_node_ff <= id_ff;
                     res_pre_ff  <= '0;
                  end
                  dgcc_pkg::ST_SELF_PREREQ, dgcc_pkg::ST_MISSING_PREREQ: begin
                     res_node_ff <= id_ff;
                     res_pre_ff  <= key_ff;
                  end
                  dgcc_pkg::ST_CYCLE, dgcc_pkg::ST_TOO_DEEP: begin
                     res_node_ff <= recid_ff;
                     res_pre_ff  <= tgt_ff;
                  end
                  default: begin
                     res_node_ff <= '0;
                     res_pre_ff  <= '0;
                  end
               endcase
            end
            dgcc_pkg::OP_EMIT: begin
               rsp_valid_ff  <= 1'b1;
               rsp_status_ff <= res_code_ff;
               rsp_node_ff   <= res_node_ff;
               rsp_pre_ff    <= res_pre_ff;
               nc_ff         <= '0;
               ec_ff         <= '0;
               ovf_ff        <= 1'b0;
               open_ff       <= 1'b0;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      sts.ovf        = ovf_ff;
      sts.n_done     = (n_ff >= nc_ff);
      sts.id_zero    = (node_rd == '0);
      sts.e_done     = (e_ff >= end_ff);
      sts.key_zero   = (key_ff == '0);
      sts.key_self   = (key_ff == id_ff);
      sts.k_done     = (k_ff >= nc_ff);
      sts.k_match    = (node_rd == key_ff);
      sts.si_done    = (si_ff >= nc_ff);
      sts.mark_new   = (mark_rd == dgcc_pkg::MARK_NEW);
      sts.mark_open  = (mark_rd == dgcc_pkg::MARK_OPEN);
      sts.sp_zero    = (sp_ff == '0);
      sts.stack_full = (sp_ff >= SP_W'(dgcc_pkg::STACK_DEPTH));
      sts.rsp_busy   = rsp_valid_ff && !rsp_ready;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_bad_node_id   = rsp_node_ff;
   assign rsp_bad_prereq_id = rsp_pre_ff;

`ifndef ASSERT_OFF
   a_node_cap: assert property (@(posedge clock) disable iff (reset)
      nc_ff <= NCNT_W'(dgcc_pkg::MAX_NODES))
      else $error("node count beyond capacity");
   a_edge_cap: assert property (@(posedge clock) disable iff (reset)
      ec_ff <= ECNT_W'(dgcc_pkg::MAX_EDGES))
      else $error("edge count beyond capacity");
   a_open_has_node: assert property (@(posedge clock) disable iff (reset)
      open_ff |-> (nc_ff != '0))
      else $error("open node without a stored node");
   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == dgcc_pkg::OP_EMIT) |=> rsp_valid_ff)
      else $error("emitted result not presented");
   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SP_W'(dgcc_pkg::STACK_DEPTH))
      else $error("walk stack pointer beyond depth");
`endif

endmodule

@@ design/dependency_graph_cycle_check_top.sv @@
// ----------------------------------------------------------------------------
// dependency_graph_cycle_check_top
// Loads a dependency graph one beat at a time and, on the last beat of the
// graph, validates its prerequisites and searches it for cycles.
// ----------------------------------------------------------------------------
// Throughput: load beats are taken one per cycle; input stalls from the beat
// with last_of_graph until the status of that graph has been handed over.
// Latency of the status is data dependent: an id search compares stored nodes
// one at a time, the marks are cleared one node a cycle, entering a node from
// the walk stack reads the stack top, its mark, record and bounds, and each
// edge reads its target and that target's mark; a node is entered again, and
// its edges rescanned, whenever a child finishes. The status is registered
// once the output is free. Synchronous active-high reset clears the node and
// edge counts; table contents are never read before they are written.
// ----------------------------------------------------------------------------
module dependency_graph_cycle_check_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [dgcc_pkg::ID_BITS-1:0]   req_node_id,
   input  logic [dgcc_pkg::ID_BITS-1:0]   req_prereq_id,
   input  logic                           req_has_prereq,
   input  logic                           req_last_of_node,
   input  logic                           req_last_of_graph,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [dgcc_pkg::STATUS_W-1:0]  rsp_status,
   output logic [dgcc_pkg::ID_BITS-1:0]   rsp_bad_node_id,
   output logic [dgcc_pkg::ID_BITS-1:0]   rsp_bad_prereq_id
);

   // The controller sequences the check; the datapath owns every table and
   // reports compare results back as status flags.
   dgcc_pkg::cmd_type cmd;
   dgcc_pkg::sts_type sts;

   dgcc_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_last_of_graph (req_last_of_graph),
      .req_ready         (req_ready),
      .sts               (sts),
      .cmd               (cmd)
   );

   dgcc_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_node_id       (req_node_id),
      .req_prereq_id     (req_prereq_id),
      .req_has_prereq    (req_has_prereq),
      .req_last_of_node  (req_last_of_node),
      .req_last_of_graph (req_last_of_graph),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_bad_node_id   (rsp_bad_node_id),
      .rsp_bad_prereq_id (rsp_bad_prereq_id)
   );

endmodule
